>>> rtl/core/ptss_pkg.sv
// Shared types and constants for the priority time-slice scheduler.
// Used by the scheduler top level and its checker; depends on nothing.
package ptss_pkg;

    localparam int DEF_MAX_TASKS = 16;
    localparam int DEF_LEVELS    = 3;

    localparam int OP_W      = 3;
    localparam int TASK_ID_W = 4;
    localparam int PRI_W     = 2;
    localparam int SLICE_W   = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_PRI  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_RUN  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd4;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRI_W-1:0]     new_priority;
    } cmd_t;

    typedef struct packed {
        logic                 run_valid;
        logic [TASK_ID_W-1:0] run_id;
        logic                 switched;
        logic                 expired;
        logic [SLICE_W-1:0]   slice_remaining;
        logic                 status_code;
    } res_t;

endpackage

>>> rtl/core/ptss_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package dependencies.
module ptss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/priority_time_slice_scheduler_top.sv
// Priority time-slice scheduler: top level with its sequencer and task table.
// Depends on ptss_pkg and ptss_ram.
//
// One command item is taken at a time and gives exactly one result item. A tick that does
// not expire, or a rejected command, takes the fewest steps; set running with a requeue,
// or a priority change of a ready task, takes the most. The length of an item is set by the
// task table RAM, which holds level, slice count and queue links of every task: each link
// change is a read of the neighbour entry followed by a write in the next cycle, and the
// sequencer performs these one after another. The running task's level and count are kept
// in registers while it runs. Presence of a task is held in one flip-flop per task that
// reset clears, so no clearing pass runs after reset. The slice length register may be
// written at any time the block is idle.
module priority_time_slice_scheduler_top
    import ptss_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SLICE_W-1:0] cfg_data
);

    localparam int TW    = $clog2(MAX_TASKS);
    localparam int LW    = $clog2(LEVELS);
    localparam int P_LSB = 0;
    localparam int N_LSB = TW;
    localparam int S_LSB = 2 * TW;
    localparam int L_LSB = 2 * TW + SLICE_W;
    localparam int WW    = L_LSB + LW;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_PUSH    = 10'b00_0000_0010,
        S_PUSH_WR = 10'b00_0000_0100,
        S_RD_REQ  = 10'b00_0000_1000,
        S_RD      = 10'b00_0001_0000,
        S_ULP_WR  = 10'b00_0010_0000,
        S_ULN_WR  = 10'b00_0100_0000,
        S_PICK_A  = 10'b00_1000_0000,
        S_PICK_B  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [TW-1:0]      tid_reg, tid_next;
    logic [LW-1:0]      pri_reg, pri_next;
    logic               status_reg, status_next;
    logic               expired_reg, expired_next;
    logic               was_present_reg, was_present_next;
    logic [TW-1:0]      was_slot_reg, was_slot_next;
    logic               run_present_reg, run_present_next;
    logic [TW-1:0]      run_slot_reg, run_slot_next;
    logic [SLICE_W-1:0] run_slice_reg, run_slice_next;
    logic [LW-1:0]      run_level_reg, run_level_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [TW-1:0]      head_reg [LEVELS];
    logic [TW-1:0]      head_next [LEVELS];
    logic [TW-1:0]      tail_reg [LEVELS];
    logic [TW-1:0]      tail_next [LEVELS];
    logic [LEVELS-1:0]  occ_reg, occ_next;
    logic [TW-1:0]      push_idx_reg, push_idx_next;
    logic [LW-1:0]      push_lvl_reg, push_lvl_next;
    logic [SLICE_W-1:0] push_slice_reg, push_slice_next;
    logic               push_tail_reg, push_tail_next;
    logic               pend_push_reg, pend_push_next;
    logic               pend_read_reg, pend_read_next;
    logic               pend_pick_reg, pend_pick_next;
    logic [WW-1:0]      ent_reg, ent_next;
    logic               ul_fix_n_reg, ul_fix_n_next;
    logic [TW-1:0]      nb_idx_reg, nb_idx_next;
    logic               nb_set_next_reg, nb_set_next_next;
    logic [LW-1:0]      pick_lvl_reg, pick_lvl_next;
    logic [SLICE_W-1:0] slice_length_reg;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic               ram_we;
    logic [TW-1:0]      ram_waddr, ram_raddr;
    logic [WW-1:0]      ram_wdata, ram_rdata;
    logic [LW-1:0]      rd_level;
    logic [SLICE_W-1:0] rd_slice;
    logic [TW-1:0]      rd_next_link, rd_prev_link;

    assign rd_level     = ram_rdata[L_LSB +: LW];
    assign rd_slice     = ram_rdata[S_LSB +: SLICE_W];
    assign rd_next_link = ram_rdata[N_LSB +: TW];
    assign rd_prev_link = ram_rdata[P_LSB +: TW];

    ptss_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Next step of an item: pushes come first, then the read of the named task, then a pick.
    function automatic state_t dispatch(input logic p, input logic r, input logic k);
        state_t s;
        if (p)
            s = S_PUSH;
        else if (r)
            s = S_RD_REQ;
        else if (k)
            s = S_PICK_A;
        else
            s = S_DONE;
        return s;
    endfunction

    always_comb
    begin
        logic          tid_ok;
        logic          pri_ok;
        logic          is_present;
        logic          is_running;
        logic          is_ready;
        logic [TW-1:0] ti;
        logic [LW-1:0] lvl;
        logic [LW-1:0] fl;
        logic          found;
        logic [WW-1:0] wd;

        state_next       = state_reg;
        op_next          = op_reg;
        tid_next         = tid_reg;
        pri_next         = pri_reg;
        status_next      = status_reg;
        expired_next     = expired_reg;
        was_present_next = was_present_reg;
        was_slot_next    = was_slot_reg;
        run_present_next = run_present_reg;
        run_slot_next    = run_slot_reg;
        run_slice_next   = run_slice_reg;
        run_level_next   = run_level_reg;
        valid_next       = valid_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        push_idx_next    = push_idx_reg;
        push_lvl_next    = push_lvl_reg;
        push_slice_next  = push_slice_reg;
        push_tail_next   = push_tail_reg;
        pend_push_next   = pend_push_reg;
        pend_read_next   = pend_read_reg;
        pend_pick_next   = pend_pick_reg;
        ent_next         = ent_reg;
        ul_fix_n_next    = ul_fix_n_reg;
        nb_idx_next      = nb_idx_reg;
        nb_set_next_next = nb_set_next_reg;
        pick_lvl_next    = pick_lvl_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;
        wd               = '0;
        found            = 1'b0;
        fl               = '0;

        ti         = TW'(cmd.task_id);
        tid_ok     = (int'(cmd.task_id) < MAX_TASKS);
        pri_ok     = (int'(cmd.new_priority) < LEVELS);
        is_present = tid_ok && valid_reg[ti];
        is_running = is_present && run_present_reg && (run_slot_reg == ti);
        is_ready   = is_present && !is_running;
        lvl        = push_lvl_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next          = cmd.opcode;
                    tid_next         = ti;
                    pri_next         = LW'(cmd.new_priority);
                    was_present_next = run_present_reg;
                    was_slot_next    = run_slot_reg;
                    status_next      = STATUS_OK;
                    expired_next     = 1'b0;
                    pend_push_next   = 1'b0;
                    pend_read_next   = 1'b0;
                    pend_pick_next   = 1'b0;
                    unique case (cmd.opcode)
                        OP_TICK:
                        begin
                            if (run_present_reg)
                            begin
                                if (run_slice_reg <= SLICE_W'(1))
                                begin
                                    expired_next     = 1'b1;
                                    run_present_next = 1'b0;
                                    push_idx_next    = run_slot_reg;
                                    push_lvl_next    = run_level_reg;
                                    push_slice_next  = slice_length_reg;
                                    push_tail_next   = 1'b1;
                                    pend_push_next   = 1'b1;
                                    pend_pick_next   = 1'b1;
                                end
                                else
                                begin
                                    run_slice_next = run_slice_reg - SLICE_W'(1);
                                end
                            end
                        end
                        OP_SCHEDULE:
                        begin
                            pend_pick_next = !run_present_reg;
                        end
                        OP_SET_PRI:
                        begin
                            if (!tid_ok || !pri_ok)
                            begin
                                status_next = STATUS_REJECT;
                            end
                            else if (!is_present)
                            begin
                                valid_next[ti]  = 1'b1;
                                push_idx_next   = ti;
                                push_lvl_next   = LW'(cmd.new_priority);
                                push_slice_next = slice_length_reg;
                                push_tail_next  = 1'b0;
                                pend_push_next  = 1'b1;
                            end
                            else if (is_ready)
                            begin
                                pend_read_next = 1'b1;
                            end
                            else
                            begin
                                run_level_next = LW'(cmd.new_priority);
                            end
                        end
                        OP_SET_RUN:
                        begin
                            if (!is_present)
                            begin
                                status_next = STATUS_REJECT;
                            end
                            else if (is_ready)
                            begin
                                if (run_present_reg)
                                begin
                                    run_present_next = 1'b0;
                                    push_idx_next    = run_slot_reg;
                                    push_lvl_next    = run_level_reg;
                                    push_slice_next  = run_slice_reg;
                                    push_tail_next   = 1'b0;
                                    pend_push_next   = 1'b1;
                                end
                                pend_read_next = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!is_present)
                            begin
                                status_next = STATUS_REJECT;
                            end
                            else
                            begin
                                valid_next[ti] = 1'b0;
                                if (is_ready)
                                begin
                                    pend_read_next = 1'b1;
                                end
                                else
                                begin
                                    run_present_next = 1'b0;
                                    run_slot_next    = '0;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_REJECT;
                        end
                    endcase
                    state_next = dispatch(pend_push_next, pend_read_next, pend_pick_next);
                end
            end

            S_PUSH:
            begin
                pend_push_next = 1'b0;
                ram_we         = 1'b1;
                ram_waddr      = push_idx_reg;
                if (!occ_reg[lvl])
                begin
                    occ_next[lvl]  = 1'b1;
                    head_next[lvl] = push_idx_reg;
                    tail_next[lvl] = push_idx_reg;
                    ram_wdata      = {lvl, push_slice_reg, {TW{1'b0}}, {TW{1'b0}}};
                    state_next     = dispatch(1'b0, pend_read_reg, pend_pick_reg);
                end
                else if (push_tail_reg)
                begin
                    ram_wdata        = {lvl, push_slice_reg, {TW{1'b0}}, tail_reg[lvl]};
                    ram_raddr        = tail_reg[lvl];
                    nb_idx_next      = tail_reg[lvl];
                    nb_set_next_next = 1'b1;
                    tail_next[lvl]   = push_idx_reg;
                    state_next       = S_PUSH_WR;
                end
                else
                begin
                    ram_wdata        = {lvl, push_slice_reg, head_reg[lvl], {TW{1'b0}}};
                    ram_raddr        = head_reg[lvl];
                    nb_idx_next      = head_reg[lvl];
                    nb_set_next_next = 1'b0;
                    head_next[lvl]   = push_idx_reg;
                    state_next       = S_PUSH_WR;
                end
            end

            S_PUSH_WR:
            begin
                // The old head or tail gets its link to the pushed task.
                wd = ram_rdata;
                if (nb_set_next_reg)
                    wd[N_LSB +: TW] = push_idx_reg;
                else
                    wd[P_LSB +: TW] = push_idx_reg;
                ram_we     = 1'b1;
                ram_waddr  = nb_idx_reg;
                ram_wdata  = wd;
                state_next = dispatch(pend_push_reg, pend_read_reg, pend_pick_reg);
            end

            S_RD_REQ:
            begin
                // Issued in the cycle after any write, so a just-patched entry reads back correctly.
                ram_raddr      = tid_reg;
                pend_read_next = 1'b0;
                state_next     = S_RD;
            end

            S_RD:
            begin
                ent_next = ram_rdata;
                if ((op_reg == OP_SET_PRI) && (rd_level == pri_reg))
                begin
                    state_next = dispatch(1'b0, 1'b0, pend_pick_reg);
                end
                else
                begin
                    if (op_reg == OP_SET_PRI)
                    begin
                        push_idx_next   = tid_reg;
                        push_lvl_next   = pri_reg;
                        push_slice_next = rd_slice;
                        push_tail_next  = 1'b0;
                        pend_push_next  = 1'b1;
                    end
                    if (op_reg == OP_SET_RUN)
                    begin
                        run_present_next = 1'b1;
                        run_slot_next    = tid_reg;
                        run_slice_next   = rd_slice;
                        run_level_next   = rd_level;
                    end
                    if (head_reg[rd_level] == tid_reg)
                    begin
                        if (tail_reg[rd_level] == tid_reg)
                            occ_next[rd_level] = 1'b0;
                        else
                            head_next[rd_level] = rd_next_link;
                        state_next = dispatch(pend_push_next, 1'b0, pend_pick_reg);
                    end
                    else
                    begin
                        ram_raddr = rd_prev_link;
                        if (tail_reg[rd_level] == tid_reg)
                        begin
                            tail_next[rd_level] = rd_prev_link;
                            ul_fix_n_next       = 1'b0;
                        end
                        else
                        begin
                            ul_fix_n_next = 1'b1;
                        end
                        state_next = S_ULP_WR;
                    end
                end
            end

            S_ULP_WR:
            begin
                wd                = ram_rdata;
                wd[N_LSB +: TW]   = ent_reg[N_LSB +: TW];
                ram_we            = 1'b1;
                ram_waddr         = ent_reg[P_LSB +: TW];
                ram_wdata         = wd;
                if (ul_fix_n_reg)
                begin
                    ram_raddr  = ent_reg[N_LSB +: TW];
                    state_next = S_ULN_WR;
                end
                else
                begin
                    state_next = dispatch(pend_push_reg, 1'b0, pend_pick_reg);
                end
            end

            S_ULN_WR:
            begin
                wd              = ram_rdata;
                wd[P_LSB +: TW] = ent_reg[P_LSB +: TW];
                ram_we          = 1'b1;
                ram_waddr       = ent_reg[N_LSB +: TW];
                ram_wdata       = wd;
                state_next      = dispatch(pend_push_reg, 1'b0, pend_pick_reg);
            end

            S_PICK_A:
            begin
                pend_pick_next = 1'b0;
                for (int i = LEVELS - 1; i >= 0; i--)
                begin
                    if (occ_reg[i])
                    begin
                        found = 1'b1;
                        fl    = LW'(i);
                    end
                end
                if (found)
                begin
                    ram_raddr     = head_reg[fl];
                    pick_lvl_next = fl;
                    state_next    = S_PICK_B;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_PICK_B:
            begin
                if (tail_reg[pick_lvl_reg] == head_reg[pick_lvl_reg])
                    occ_next[pick_lvl_reg] = 1'b0;
                else
                    head_next[pick_lvl_reg] = rd_next_link;
                run_present_next = 1'b1;
                run_slot_next    = head_reg[pick_lvl_reg];
                run_slice_next   = rd_slice;
                run_level_next   = rd_level;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next           = 1'b1;
                    res_next.run_valid       = run_present_reg;
                    res_next.run_id          = run_present_reg ? TASK_ID_W'(run_slot_reg) : '0;
                    res_next.switched        = (was_present_reg != run_present_reg) ||
                                               (run_present_reg && (was_slot_reg != run_slot_reg));
                    res_next.expired         = expired_reg;
                    res_next.slice_remaining = run_present_reg ? run_slice_reg : '0;
                    res_next.status_code     = status_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            run_present_reg  <= 1'b0;
            run_slot_reg     <= '0;
            valid_reg        <= '0;
            occ_reg          <= '0;
            pend_push_reg    <= 1'b0;
            pend_read_reg    <= 1'b0;
            pend_pick_reg    <= 1'b0;
            slice_length_reg <= SLICE_RESET;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            run_present_reg <= run_present_next;
            run_slot_reg    <= run_slot_next;
            valid_reg       <= valid_next;
            occ_reg         <= occ_next;
            pend_push_reg   <= pend_push_next;
            pend_read_reg   <= pend_read_next;
            pend_pick_reg   <= pend_pick_next;
            res_valid_reg   <= res_valid_next;
            if (cfg_valid)
            begin
                slice_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        tid_reg         <= tid_next;
        pri_reg         <= pri_next;
        status_reg      <= status_next;
        expired_reg     <= expired_next;
        was_present_reg <= was_present_next;
        was_slot_reg    <= was_slot_next;
        run_slice_reg   <= run_slice_next;
        run_level_reg   <= run_level_next;
        head_reg        <= head_next;
        tail_reg        <= tail_next;
        push_idx_reg    <= push_idx_next;
        push_lvl_reg    <= push_lvl_next;
        push_slice_reg  <= push_slice_next;
        push_tail_reg   <= push_tail_next;
        ent_reg         <= ent_next;
        ul_fix_n_reg    <= ul_fix_n_next;
        nb_idx_reg      <= nb_idx_next;
        nb_set_next_reg <= nb_set_next_next;
        pick_lvl_reg    <= pick_lvl_next;
        res_reg         <= res_next;
    end

endmodule

>>> rtl/core/ptss_checker.sv
// Port-level checks for the priority time-slice scheduler, bound to its top level.
// Depends on ptss_pkg for the result item type and the status codes.
module ptss_checker
    import ptss_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // A result that waits must hold.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // One item is worked on at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second item taken while one is in progress");

    // An empty run slot reports slot zero and no remaining ticks.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.run_valid |-> (res.run_id == '0) && (res.slice_remaining == '0))
        else $error("empty run slot with non-zero fields");

    // An expired task is requeued and a task is always chosen again.
    a_expire_runs: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.expired |-> res.run_valid)
        else $error("expiry left the run slot empty");

    // A rejected item changes nothing.
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status_code == STATUS_REJECT) |-> !res.switched && !res.expired)
        else $error("rejected item changed the run slot");

endmodule

bind priority_time_slice_scheduler_top ptss_checker u_ptss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
